// ===== rtl/gvh_pkg.sv =====
package gvh_pkg;

   localparam int ID_BITS     = 12;
   localparam int ID_COUNT    = 4096;
   localparam int COUNT_BITS  = 16;
   localparam int TOTAL_BITS  = 13;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_DELETE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_PRESENT = 2'd1,
      ST_ABSENT  = 2'd2,
      ST_FULL    = 2'd3
   } status_type;

   // What the sequencer resumes with once a sift finishes.
   typedef enum logic [1:0] {
      CTX_INSERT,
      CTX_DOWN,
      CTX_UP_AFTER_DELETE
   } ctx_type;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOK,
      S_DEL_M,
      S_DEL_R0,
      S_DEL_RL,
      S_SETUP,
      S_R0,
      S_R1,
      S_R2,
      S_R3,
      S_DEC,
      S_SW1,
      S_SW2,
      S_DONE,
      S_DEL_P,
      S_DEL_CLR,
      S_TOP,
      S_OUT
   } state_type;

endpackage

// ===== rtl/gvh_cmp.sv =====
module gvh_cmp #(
   parameter int KEY_W = 16
) (
   input  logic             cand_ok,
   input  logic [KEY_W-1:0] cand_key,
   input  logic [KEY_W-1:0] best_key,
   output logic             take
);

   // Strict less-than: a tie keeps the current best.
   assign take = cand_ok && (cand_key < best_key);

endmodule

// ===== rtl/gvh_heap_ram.sv =====
module gvh_heap_ram #(
   parameter int DEPTH     = 4096,
   parameter int SLOT_BITS = 12,
   parameter int KEY_W     = 16
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [SLOT_BITS-1:0]        wr_addr,
   input  logic [gvh_pkg::ID_BITS-1:0] wr_id,
   input  logic [KEY_W-1:0]            wr_key,
   input  logic                        rd_en,
   input  logic [SLOT_BITS-1:0]        rd_addr,
   output logic [gvh_pkg::ID_BITS-1:0] rd_id,
   output logic [KEY_W-1:0]            rd_key
);
   import gvh_pkg::*;

   logic [ID_BITS-1:0] id_mem  [DEPTH];
   logic [KEY_W-1:0]   key_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         id_mem[wr_addr]  <= wr_id;
         key_mem[wr_addr] <= wr_key;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_id  <= id_mem[rd_addr];
         rd_key <= key_mem[rd_addr];
      end
   end

endmodule

// ===== rtl/gvh_pos_ram.sv =====
module gvh_pos_ram #(
   parameter int SLOT_BITS = 12
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [gvh_pkg::ID_BITS-1:0] wr_addr,
   input  logic                        wr_present,
   input  logic [SLOT_BITS-1:0]        wr_slot,
   input  logic                        rd_en,
   input  logic [gvh_pkg::ID_BITS-1:0] rd_addr,
   output logic                        rd_present,
   output logic [SLOT_BITS-1:0]        rd_slot
);
   import gvh_pkg::*;

   logic [SLOT_BITS:0] mem [ID_COUNT];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_present, wr_slot};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         {rd_present, rd_slot} <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/gc_victim_min_heap.sv =====
// Indexed binary min-heap of erase-unit ids keyed by valid-page count.
// Input channel (req_*): one item is an insert or a delete by id, taken when
// req_valid and req_ready are both high. Result channel (rsp_*): exactly one
// item per input item, carrying the status, whether a deleted key was zero,
// and the heap minimum and entry count after the operation.
// The block works on one item at a time. req_ready is low from acceptance
// until the result item has been taken, so a stalled receiver simply holds
// the block with the result steady on the rsp_ports.
// Each item is sequenced around the heap memory's single read port and the
// shared key comparator: each heap level steps through setup, three reads
// with two compares, decide, and two swap writes. An insert sifts up; a
// delete sifts down and then, where needed, up. The number of levels that
// swap is at most log2(MAX_ENTRIES) in each direction.
// After reset the id position table is swept once, one id per cycle, and
// req_ready stays low until the sweep is done. The heap slots themselves
// need no clearing since only slots below the count are used.
module gc_victim_min_heap #(
   parameter int MAX_ENTRIES = 4096,
   parameter int KEY_BITS    = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_cmd,
   input  logic [gvh_pkg::ID_BITS-1:0]   req_entry_id,
   input  logic [gvh_pkg::COUNT_BITS-1:0] req_valid_count,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_removed_was_empty,
   output logic                          rsp_top_present,
   output logic [gvh_pkg::ID_BITS-1:0]   rsp_top_id,
   output logic [gvh_pkg::COUNT_BITS-1:0] rsp_top_count,
   output logic [gvh_pkg::TOTAL_BITS-1:0] rsp_entry_total
);
   import gvh_pkg::*;

   // Keys only ever carry the bits of the input field.
   localparam int KW = (KEY_BITS < COUNT_BITS) ? KEY_BITS : COUNT_BITS;
   localparam int SW = $clog2(MAX_ENTRIES);
   localparam int NW = $clog2(MAX_ENTRIES + 1);
   localparam int CW = SW + 2;

   state_type          state_ff, state_in;
   logic [ID_BITS-1:0] clr_ff, clr_in;
   cmd_type            cmd_ff, cmd_in;
   logic [ID_BITS-1:0] id_ff, id_in;
   logic [KW-1:0]      key_ff, key_in;
   logic [NW-1:0]      size_ff, size_in;
   status_type         status_ff, status_in;
   logic               empty_ff, empty_in;
   logic [SW-1:0]      m_ff, m_in;
   ctx_type            ctx_ff, ctx_in;
   logic               up_ff, up_in;
   logic [SW-1:0]      idx_ff, idx_in;
   logic [SW-1:0]      first_ff, first_in;
   logic [CW-1:0]      c1_ff, c1_in;
   logic [CW-1:0]      c2_ff, c2_in;
   logic [SW-1:0]      bslot_ff, bslot_in;
   logic [ID_BITS-1:0] bid_ff, bid_in;
   logic [KW-1:0]      bkey_ff, bkey_in;
   logic [ID_BITS-1:0] nid_ff, nid_in;
   logic [KW-1:0]      nkey_ff, nkey_in;
   logic [ID_BITS-1:0] rid_ff, rid_in;
   logic [KW-1:0]      rkey_ff, rkey_in;

   // Memory ports.
   logic               h_we, h_re;
   logic [SW-1:0]      h_waddr, h_raddr;
   logic [ID_BITS-1:0] h_wid, h_rid;
   logic [KW-1:0]      h_wkey, h_rkey;
   logic               p_we, p_re, p_wpresent, p_rpresent;
   logic [ID_BITS-1:0] p_waddr, p_raddr;
   logic [SW-1:0]      p_wslot, p_rslot;

   // Shared comparator.
   logic               cmp_ok, cmp_take;

   logic [SW-1:0]      last_slot;
   logic               heap_full;
   logic               pos_in_range;

   assign last_slot    = SW'(size_ff - NW'(1));
   assign heap_full    = (size_ff == NW'(MAX_ENTRIES));
   assign pos_in_range = (NW'(p_rslot) < size_ff);

   gvh_heap_ram #(
      .DEPTH     (MAX_ENTRIES),
      .SLOT_BITS (SW),
      .KEY_W     (KW)
   ) u_heap (
      .clock   (clock),
      .wr_en   (h_we),
      .wr_addr (h_waddr),
      .wr_id   (h_wid),
      .wr_key  (h_wkey),
      .rd_en   (h_re),
      .rd_addr (h_raddr),
      .rd_id   (h_rid),
      .rd_key  (h_rkey)
   );

   gvh_pos_ram #(
      .SLOT_BITS (SW)
   ) u_pos (
      .clock      (clock),
      .wr_en      (p_we),
      .wr_addr    (p_waddr),
      .wr_present (p_wpresent),
      .wr_slot    (p_wslot),
      .rd_en      (p_re),
      .rd_addr    (p_raddr),
      .rd_present (p_rpresent),
      .rd_slot    (p_rslot)
   );

   // The comparator sees the first child candidate in S_R2, the second in S_R3.
   always_comb begin
      cmp_ok = 1'b0;
      if (state_ff == S_R2) begin
         cmp_ok = (c1_ff < CW'(size_ff));
      end else if (state_ff == S_R3) begin
         cmp_ok = (c2_ff < CW'(size_ff));
      end
   end

   gvh_cmp #(
      .KEY_W (KW)
   ) u_cmp (
      .cand_ok  (cmp_ok),
      .cand_key (h_rkey),
      .best_key (bkey_ff),
      .take     (cmp_take)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_ff == '1) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) state_in = S_LOOK;
         end
         S_LOOK: begin
            if (cmd_ff == CMD_INSERT) begin
               state_in = (p_rpresent || heap_full) ? S_TOP : S_SETUP;
            end else begin
               state_in = (p_rpresent && pos_in_range) ? S_DEL_M : S_TOP;
            end
         end
         S_DEL_M: begin
            state_in = (m_ff == last_slot) ? S_DEL_CLR : S_DEL_R0;
         end
         S_DEL_R0: state_in = S_DEL_RL;
         S_DEL_RL: state_in = S_SETUP;
         S_SETUP: begin
            if (up_ff && (idx_ff == '0 || NW'(idx_ff) >= size_ff)) begin
               state_in = S_DONE;
            end else begin
               state_in = S_R0;
            end
         end
         S_R0: state_in = S_R1;
         S_R1: state_in = S_R2;
         S_R2: state_in = S_R3;
         S_R3: state_in = S_DEC;
         S_DEC: state_in = (bslot_ff != first_ff) ? S_SW1 : S_DONE;
         S_SW1: state_in = S_SW2;
         S_SW2: state_in = S_SETUP;
         S_DONE: begin
            case (ctx_ff)
               CTX_INSERT: state_in = S_TOP;
               CTX_DOWN:   state_in = (m_ff != '0) ? S_DEL_P : S_DEL_CLR;
               default:    state_in = S_DEL_CLR;
            endcase
         end
         S_DEL_P: state_in = pos_in_range ? S_SETUP : S_DEL_CLR;
         S_DEL_CLR: state_in = S_TOP;
         S_TOP: state_in = S_OUT;
         S_OUT: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Memory controls and handshake outputs.
   always_comb begin
      h_we       = 1'b0;
      h_waddr    = '0;
      h_wid      = '0;
      h_wkey     = '0;
      h_re       = 1'b0;
      h_raddr    = '0;
      p_we       = 1'b0;
      p_waddr    = '0;
      p_wpresent = 1'b0;
      p_wslot    = '0;
      p_re       = 1'b0;
      p_raddr    = '0;
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            p_we    = 1'b1;
            p_waddr = clr_ff;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            p_re      = 1'b1;
            p_raddr   = req_entry_id;
         end
         S_LOOK: begin
            if (cmd_ff == CMD_INSERT) begin
               if (!p_rpresent && !heap_full) begin
                  h_we       = 1'b1;
                  h_waddr    = SW'(size_ff);
                  h_wid      = id_ff;
                  h_wkey     = key_ff;
                  p_we       = 1'b1;
                  p_waddr    = id_ff;
                  p_wpresent = 1'b1;
                  p_wslot    = SW'(size_ff);
               end
            end else begin
               h_re    = 1'b1;
               h_raddr = p_rslot;
            end
         end
         S_DEL_M: begin
            h_re    = 1'b1;
            h_raddr = '0;
         end
         S_DEL_R0: begin
            h_re    = 1'b1;
            h_raddr = last_slot;
         end
         S_DEL_RL: begin
            // The last entry becomes the new root.
            h_we       = 1'b1;
            h_waddr    = '0;
            h_wid      = h_rid;
            h_wkey     = h_rkey;
            p_we       = 1'b1;
            p_waddr    = h_rid;
            p_wpresent = 1'b1;
            p_wslot    = '0;
         end
         S_R0: begin
            h_re    = 1'b1;
            h_raddr = first_ff;
         end
         S_R1: begin
            h_re    = 1'b1;
            h_raddr = SW'(c1_ff);
         end
         S_R2: begin
            h_re    = 1'b1;
            h_raddr = SW'(c2_ff);
         end
         S_SW1: begin
            h_we       = 1'b1;
            h_waddr    = bslot_ff;
            h_wid      = nid_ff;
            h_wkey     = nkey_ff;
            p_we       = 1'b1;
            p_waddr    = nid_ff;
            p_wpresent = 1'b1;
            p_wslot    = bslot_ff;
         end
         S_SW2: begin
            h_we       = 1'b1;
            h_waddr    = first_ff;
            h_wid      = bid_ff;
            h_wkey     = bkey_ff;
            p_we       = 1'b1;
            p_waddr    = bid_ff;
            p_wpresent = 1'b1;
            p_wslot    = first_ff;
         end
         S_DONE: begin
            p_re    = 1'b1;
            p_raddr = id_ff;
         end
         S_DEL_P: begin
            // The old root fills the slot the deleted entry holds now.
            if (pos_in_range) begin
               h_we       = 1'b1;
               h_waddr    = p_rslot;
               h_wid      = rid_ff;
               h_wkey     = rkey_ff;
               p_we       = 1'b1;
               p_waddr    = rid_ff;
               p_wpresent = 1'b1;
               p_wslot    = p_rslot;
            end
         end
         S_DEL_CLR: begin
            p_we    = 1'b1;
            p_waddr = id_ff;
         end
         S_TOP: begin
            h_re    = 1'b1;
            h_raddr = '0;
         end
         S_OUT: begin
            rsp_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      clr_in    = clr_ff;
      cmd_in    = cmd_ff;
      id_in     = id_ff;
      key_in    = key_ff;
      size_in   = size_ff;
      status_in = status_ff;
      empty_in  = empty_ff;
      m_in      = m_ff;
      ctx_in    = ctx_ff;
      up_in     = up_ff;
      idx_in    = idx_ff;
      first_in  = first_ff;
      c1_in     = c1_ff;
      c2_in     = c2_ff;
      bslot_in  = bslot_ff;
      bid_in    = bid_ff;
      bkey_in   = bkey_ff;
      nid_in    = nid_ff;
      nkey_in   = nkey_ff;
      rid_in    = rid_ff;
      rkey_in   = rkey_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + ID_BITS'(1);
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd_in    = cmd_type'(req_cmd);
               id_in     = req_entry_id;
               key_in    = req_valid_count[KW-1:0];
               status_in = ST_OK;
               empty_in  = 1'b0;
            end
         end
         S_LOOK: begin
            if (cmd_ff == CMD_INSERT) begin
               if (p_rpresent) begin
                  status_in = ST_PRESENT;
               end else if (heap_full) begin
                  status_in = ST_FULL;
               end else begin
                  size_in = size_ff + NW'(1);
                  idx_in  = SW'(size_ff);
                  up_in   = 1'b1;
                  ctx_in  = CTX_INSERT;
               end
            end else begin
               if (p_rpresent && pos_in_range) begin
                  m_in = p_rslot;
               end else begin
                  status_in = ST_ABSENT;
               end
            end
         end
         S_DEL_M: begin
            empty_in = (h_rkey == '0);
            if (m_ff == last_slot) begin
               size_in = size_ff - NW'(1);
            end
         end
         S_DEL_R0: begin
            rid_in  = h_rid;
            rkey_in = h_rkey;
         end
         S_DEL_RL: begin
            size_in = size_ff - NW'(1);
            idx_in  = '0;
            up_in   = 1'b0;
            ctx_in  = CTX_DOWN;
         end
         S_SETUP: begin
            if (up_ff) begin
               // Parent, then sibling, then the node itself.
               first_in = (idx_ff - SW'(1)) >> 1;
               c1_in    = idx_ff[0] ? (CW'(idx_ff) + CW'(1)) : (CW'(idx_ff) - CW'(1));
               c2_in    = CW'(idx_ff);
            end else begin
               // Node, then right child, then left child.
               first_in = idx_ff;
               c2_in    = {1'b0, idx_ff, 1'b1};
               c1_in    = {1'b0, idx_ff, 1'b1} + CW'(1);
            end
         end
         S_R1: begin
            bslot_in = first_ff;
            bid_in   = h_rid;
            bkey_in  = h_rkey;
            nid_in   = h_rid;
            nkey_in  = h_rkey;
         end
         S_R2: begin
            if (cmp_take) begin
               bslot_in = SW'(c1_ff);
               bid_in   = h_rid;
               bkey_in  = h_rkey;
            end
         end
         S_R3: begin
            if (cmp_take) begin
               bslot_in = SW'(c2_ff);
               bid_in   = h_rid;
               bkey_in  = h_rkey;
            end
         end
         S_SW2: begin
            idx_in = up_ff ? first_ff : bslot_ff;
         end
         S_DEL_P: begin
            if (pos_in_range) begin
               idx_in = p_rslot;
               up_in  = 1'b1;
               ctx_in = CTX_UP_AFTER_DELETE;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         size_ff  <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         size_ff  <= size_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      id_ff     <= id_in;
      key_ff    <= key_in;
      status_ff <= status_in;
      empty_ff  <= empty_in;
      m_ff      <= m_in;
      ctx_ff    <= ctx_in;
      up_ff     <= up_in;
      idx_ff    <= idx_in;
      first_ff  <= first_in;
      c1_ff     <= c1_in;
      c2_ff     <= c2_in;
      bslot_ff  <= bslot_in;
      bid_ff    <= bid_in;
      bkey_ff   <= bkey_in;
      nid_ff    <= nid_in;
      nkey_ff   <= nkey_in;
      rid_ff    <= rid_in;
      rkey_ff   <= rkey_in;
   end

   // The root read in S_TOP stays in the memory's output register while the
   // result waits.
   assign rsp_status            = status_ff;
   assign rsp_removed_was_empty = empty_ff;
   assign rsp_top_present       = (size_ff != '0);
   assign rsp_top_id            = (size_ff != '0) ? h_rid : '0;
   assign rsp_top_count         = (size_ff != '0) ? COUNT_BITS'(h_rkey) : '0;
   assign rsp_entry_total       = TOTAL_BITS'(size_ff);

endmodule

// ===== rtl/gvh_checker.sv =====
module gvh_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           req_cmd,
   input logic [gvh_pkg::ID_BITS-1:0]    req_entry_id,
   input logic [gvh_pkg::COUNT_BITS-1:0] req_valid_count,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [1:0]                     rsp_status,
   input logic                           rsp_removed_was_empty,
   input logic                           rsp_top_present,
   input logic [gvh_pkg::ID_BITS-1:0]    rsp_top_id,
   input logic [gvh_pkg::COUNT_BITS-1:0] rsp_top_count,
   input logic [gvh_pkg::TOTAL_BITS-1:0] rsp_entry_total
);
   import gvh_pkg::*;

   // A result held by the receiver does not change.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_top_id) && $stable(rsp_top_count) && $stable(rsp_entry_total))
      else $error("result changed while stalled");

   // One item at a time: no new item while a result is pending.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input ready while a result is pending");

   // An accepted item is never answered in the very next cycle.
   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid)
      else $error("result too early");

   // Only a successful delete can report an empty removed unit.
   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> !rsp_removed_was_empty)
      else $error("empty flag on a failed item");

   // An empty heap shows a zero minimum.
   a_empty_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_top_present |-> rsp_top_id == '0 && rsp_top_count == '0)
      else $error("minimum shown for an empty heap");

endmodule

bind gc_victim_min_heap gvh_checker u_gvh_checker (.*);
